// ===== rtl/small_language_lexer_unit_macros.svh =====
// Assertion macros used by the lexer top level.
`ifndef SMALL_LANGUAGE_LEXER_UNIT_MACROS_SVH
`define SMALL_LANGUAGE_LEXER_UNIT_MACROS_SVH

// Same-cycle implication, checked at every clock edge out of reset.
`define SLL_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked at every clock edge out of reset.
`define SLL_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/sll_pkg.sv =====
// Types, token codes and character classes of the small language lexer.
`timescale 1ns / 1ps

package sll_pkg;

    typedef enum logic [2:0] {
        MODE_IDLE,
        MODE_IDENT,
        MODE_NUM,
        MODE_COLON,
        MODE_LESS,
        MODE_GREATER
    } t_mode;

    localparam logic [4:0] TOK_END     = 5'd0;
    localparam logic [4:0] TOK_IDENT   = 5'd10;
    localparam logic [4:0] TOK_NUMBER  = 5'd11;
    localparam logic [4:0] TOK_PLUS    = 5'd13;
    localparam logic [4:0] TOK_MINUS   = 5'd14;
    localparam logic [4:0] TOK_STAR    = 5'd15;
    localparam logic [4:0] TOK_SLASH   = 5'd16;
    localparam logic [4:0] TOK_COLON   = 5'd17;
    localparam logic [4:0] TOK_ASSIGN  = 5'd18;
    localparam logic [4:0] TOK_LESS    = 5'd20;
    localparam logic [4:0] TOK_NEQ     = 5'd21;
    localparam logic [4:0] TOK_LEQ     = 5'd22;
    localparam logic [4:0] TOK_GREATER = 5'd23;
    localparam logic [4:0] TOK_GEQ     = 5'd24;
    localparam logic [4:0] TOK_EQUAL   = 5'd25;
    localparam logic [4:0] TOK_SEMI    = 5'd26;
    localparam logic [4:0] TOK_LPAREN  = 5'd27;
    localparam logic [4:0] TOK_RPAREN  = 5'd28;

    localparam logic [7:0] CH_HASH    = 8'h23;
    localparam logic [7:0] CH_COLON   = 8'h3A;
    localparam logic [7:0] CH_LESS    = 8'h3C;
    localparam logic [7:0] CH_EQUAL   = 8'h3D;
    localparam logic [7:0] CH_GREATER = 8'h3E;

    localparam int KW_COUNT = 6;

    // One result word that does not come from the lexeme buffer.
    typedef struct packed {
        logic [4:0] code;
        logic [7:0] ch;
        logic       last;
        logic       bad;
    } t_res;

    // Up to two short results, after a flushed word if there is one.
    typedef struct packed {
        logic [1:0] cnt;
        t_res       t0;
        t_res       t1;
    } t_tail;

    function automatic logic is_alpha(input logic [7:0] c);
        is_alpha = (c >= 8'h61 && c <= 8'h7A) || (c >= 8'h41 && c <= 8'h5A);
    endfunction

    function automatic logic is_digit(input logic [7:0] c);
        is_digit = (c >= 8'h30 && c <= 8'h39);
    endfunction

    function automatic logic is_sep(input logic [7:0] c);
        is_sep = (c == 8'h20) || (c == 8'h2C) || (c == 8'h09) || (c == 8'h0A) ||
                 (c == 8'h0D) || (c == 8'h0B) || (c == 8'h0C);
    endfunction

    // Code of a one-character operator, TOK_END when c is none.
    function automatic logic [4:0] single_code(input logic [7:0] c);
        case (c)
            8'h2B:   single_code = TOK_PLUS;
            8'h2D:   single_code = TOK_MINUS;
            8'h2A:   single_code = TOK_STAR;
            8'h2F:   single_code = TOK_SLASH;
            8'h3D:   single_code = TOK_EQUAL;
            8'h3B:   single_code = TOK_SEMI;
            8'h28:   single_code = TOK_LPAREN;
            8'h29:   single_code = TOK_RPAREN;
            default: single_code = TOK_END;
        endcase
    endfunction

    // Keyword k is token code k + 1.
    function automatic logic [2:0] kw_len(input logic [2:0] k);
        case (k)
            3'd0:    kw_len = 3'd5;
            3'd1:    kw_len = 3'd2;
            3'd2:    kw_len = 3'd4;
            3'd3:    kw_len = 3'd5;
            3'd4:    kw_len = 3'd2;
            3'd5:    kw_len = 3'd3;
            default: kw_len = 3'd0;
        endcase
    endfunction

    function automatic logic [7:0] kw_char(input logic [2:0] k, input logic [2:0] p);
        logic [39:0] w;
        case (k)
            3'd0:    w = "begin";
            3'd1:    w = {"if", 24'h0};
            3'd2:    w = {"then", 8'h0};
            3'd3:    w = "while";
            3'd4:    w = {"do", 24'h0};
            3'd5:    w = {"end", 16'h0};
            default: w = '0;
        endcase
        case (p)
            3'd0:    kw_char = w[39:32];
            3'd1:    kw_char = w[31:24];
            3'd2:    kw_char = w[23:16];
            3'd3:    kw_char = w[15:8];
            3'd4:    kw_char = w[7:0];
            default: kw_char = 8'h00;
        endcase
    endfunction

endpackage

// ===== rtl/sll_scanner.sv =====
// Scanner state machine: classifies each character and plans the results it causes.
`timescale 1ns / 1ps

module sll_scanner #(
    parameter int MAX_LEXEME = 16,
    parameter int LW = $clog2(MAX_LEXEME),
    parameter int CW = $clog2(MAX_LEXEME + 1)
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_take,
    input  logic [7:0]    i_char,
    output logic          o_need_job,
    output logic [CW-1:0] o_word_len,
    output logic [4:0]    o_word_code,
    output logic          o_word_trunc,
    output logic          o_word_bank,
    output sll_pkg::t_tail o_tail,
    output logic          o_wr_en,
    output logic [LW:0]   o_wr_addr
);
    import sll_pkg::*;

    t_mode                r_mode, n_mode;
    logic [CW-1:0]        r_len, n_len;
    logic                 r_ovf, n_ovf;
    logic                 r_bank, n_bank;
    logic [KW_COUNT-1:0]  r_kw, n_kw;

    logic                 flush;
    logic                 rest;
    logic                 wr_en;
    logic [LW-1:0]        wr_idx;
    t_tail                tail;
    t_res                 res;
    logic [7:0]           first;
    logic [4:0]           pair;
    logic [4:0]           word_code;

    // Keyword hit of the word held now.
    always_comb begin
        word_code = (r_mode == MODE_NUM) ? TOK_NUMBER : TOK_IDENT;
        if (r_mode == MODE_IDENT && !r_ovf) begin
            for (int k = KW_COUNT - 1; k >= 0; k--) begin
                if (r_kw[k] && r_len == CW'(kw_len(3'(k)))) begin
                    word_code = 5'(k + 1);
                end
            end
        end
    end

    always_comb begin
        n_mode = r_mode;
        n_len  = r_len;
        n_ovf  = r_ovf;
        n_bank = r_bank;
        n_kw   = r_kw;
        flush  = 1'b0;
        rest   = 1'b0;
        wr_en  = 1'b0;
        wr_idx = r_len[LW-1:0];
        tail   = '0;
        res    = '0;
        first  = CH_COLON;
        pair   = TOK_END;

        case (r_mode)
            MODE_COLON, MODE_LESS, MODE_GREATER: begin
                first = (r_mode == MODE_COLON) ? CH_COLON :
                        (r_mode == MODE_LESS)  ? CH_LESS : CH_GREATER;
                if (r_mode == MODE_COLON && i_char == CH_EQUAL) begin
                    pair = TOK_ASSIGN;
                end else if (r_mode == MODE_LESS && i_char == CH_GREATER) begin
                    pair = TOK_NEQ;
                end else if (r_mode == MODE_LESS && i_char == CH_EQUAL) begin
                    pair = TOK_LEQ;
                end else if (r_mode == MODE_GREATER && i_char == CH_EQUAL) begin
                    pair = TOK_GEQ;
                end
                n_mode = MODE_IDLE;
                if (pair != TOK_END) begin
                    tail.cnt = 2'd2;
                    tail.t0  = '{code: pair, ch: first, last: 1'b0, bad: 1'b0};
                    tail.t1  = '{code: pair, ch: i_char, last: 1'b1, bad: 1'b0};
                end else begin
                    tail.cnt = 2'd1;
                    tail.t0  = '{code: (r_mode == MODE_COLON) ? TOK_COLON :
                                       (r_mode == MODE_LESS) ? TOK_LESS : TOK_GREATER,
                                 ch: first, last: 1'b1, bad: 1'b0};
                    rest     = 1'b1;
                end
            end
            MODE_IDENT, MODE_NUM: begin
                if (is_digit(i_char) || (r_mode == MODE_IDENT && is_alpha(i_char))) begin
                    // Append to the open word, or mark it cut.
                    if (r_len < CW'(MAX_LEXEME)) begin
                        wr_en = 1'b1;
                        n_len = r_len + CW'(1);
                        for (int k = 0; k < KW_COUNT; k++) begin
                            n_kw[k] = r_kw[k] && (r_len < CW'(kw_len(3'(k)))) &&
                                      (i_char == kw_char(3'(k), r_len[2:0]));
                        end
                    end else begin
                        n_ovf = 1'b1;
                    end
                end else begin
                    flush  = 1'b1;
                    rest   = 1'b1;
                    n_mode = MODE_IDLE;
                    n_len  = '0;
                    n_ovf  = 1'b0;
                    n_bank = ~r_bank;
                end
            end
            default: begin
                rest   = 1'b1;
                n_mode = MODE_IDLE;
            end
        endcase

        if (rest) begin
            if (is_alpha(i_char) || is_digit(i_char)) begin
                n_mode = is_alpha(i_char) ? MODE_IDENT : MODE_NUM;
                n_len  = CW'(1);
                n_ovf  = 1'b0;
                wr_en  = 1'b1;
                wr_idx = '0;
                for (int k = 0; k < KW_COUNT; k++) begin
                    n_kw[k] = (i_char == kw_char(3'(k), 3'd0));
                end
            end else if (i_char == CH_COLON) begin
                n_mode = MODE_COLON;
            end else if (i_char == CH_LESS) begin
                n_mode = MODE_LESS;
            end else if (!is_sep(i_char)) begin
                if (i_char == CH_HASH) begin
                    res = '{code: TOK_END, ch: i_char, last: 1'b1, bad: 1'b0};
                end else begin
                    res = '{code: single_code(i_char), ch: i_char, last: 1'b1,
                            bad: (single_code(i_char) == TOK_END)};
                end
                if (i_char == CH_GREATER) begin
                    n_mode = MODE_GREATER;
                end else begin
                    if (tail.cnt == 2'd0) begin
                        tail.t0 = res;
                    end else begin
                        tail.t1 = res;
                    end
                    tail.cnt = tail.cnt + 2'd1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= MODE_IDLE;
            r_len  <= '0;
            r_ovf  <= 1'b0;
            r_bank <= 1'b0;
            r_kw   <= '0;
        end else if (i_take) begin
            r_mode <= n_mode;
            r_len  <= n_len;
            r_ovf  <= n_ovf;
            r_bank <= n_bank;
            r_kw   <= n_kw;
        end
    end

    assign o_need_job   = flush || (tail.cnt != 2'd0);
    assign o_word_len   = flush ? r_len : '0;
    assign o_word_code  = word_code;
    assign o_word_trunc = r_ovf;
    assign o_word_bank  = r_bank;
    assign o_tail       = tail;
    assign o_wr_en      = i_take && wr_en;
    assign o_wr_addr    = {n_bank, wr_idx};

endmodule

// ===== rtl/small_language_lexer_unit.sv =====
// Top level of the streaming lexer: scanner, lexeme memory and result sequencer.
//
// Streaming tokenizer for a small language. Feed one source character per
// word on the input channel; tokens leave on the output channel as bursts of
// words, one per lexeme character, each carrying the token code, with
// o_last_char set on the final character. Keywords (begin, if, then, while,
// do, end; lowercase only) are codes 1 to 6, identifiers 10, unsigned numbers
// 11, operators 13 to 28, the end mark '#' code 0, and an unknown character
// comes back alone with o_bad_char set. Lexemes longer than MAX_LEXEME are cut
// and every one of their words has o_truncated set. Throughput: a character
// is taken in every cycle as long as the character does not close a token
// while the previous token is still being read out. A token of L characters
// plus up to two operator or marker words leaves at one word per cycle while
// i_out_stall is low, limited by the single read port of the two-bank lexeme
// memory; a character that closes a token waits (o_in_stall high) until the
// burst before it has been fully issued. The first result word passes the job
// slot, read stage and output register. No clearing pass after reset: the
// memory is only read at entries written by the current word.
`timescale 1ns / 1ps

`include "small_language_lexer_unit_macros.svh"

module small_language_lexer_unit #(
    parameter int MAX_LEXEME = 16
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_stall,
    input  logic [7:0] i_in_char,
    output logic       o_out_valid,
    input  logic       i_out_stall,
    output logic [4:0] o_token_code,
    output logic [7:0] o_lexeme_char,
    output logic       o_last_char,
    output logic       o_truncated,
    output logic       o_bad_char
);
    import sll_pkg::*;

    localparam int LW    = $clog2(MAX_LEXEME);
    localparam int CW    = $clog2(MAX_LEXEME + 1);
    localparam int PW    = $clog2(MAX_LEXEME + 3);
    localparam int DEPTH = 2 * (2 ** LW);

    // Scanner outputs.
    logic          need_job;
    logic [CW-1:0] sc_len;
    logic [4:0]    sc_code;
    logic          sc_trunc;
    logic          sc_bank;
    t_tail         sc_tail;
    logic          wr_en;
    logic [LW:0]   wr_addr;

    // Handshake and sequencing.
    logic take;
    logic load;
    logic out_free;
    logic rd_free;
    logic issue;
    logic slot_free;

    // Job slot: one closed token plus its trailing words.
    logic          r_job_valid;
    logic [CW-1:0] r_job_len;
    logic [4:0]    r_job_code;
    logic          r_job_trunc;
    logic          r_job_bank;
    t_tail         r_job_tail;
    logic [PW-1:0] r_job_pos;
    logic [PW-1:0] job_total;
    logic [PW-1:0] tail_pos;
    logic          in_word;
    logic          job_last;
    t_res          tail_res;

    // Read stage, lines up with the registered memory read.
    logic       r_rd_valid;
    logic       r_rd_mem;
    logic [4:0] r_rd_code;
    logic [7:0] r_rd_ch;
    logic       r_rd_last;
    logic       r_rd_trunc;
    logic       r_rd_bad;
    logic [7:0] r_rd_data;

    // Output register.
    logic       r_o_valid;
    logic [4:0] r_o_code;
    logic [7:0] r_o_char;
    logic       r_o_last;
    logic       r_o_trunc;
    logic       r_o_bad;

    // Two banks: the scanner fills one while the sequencer reads the other.
    logic [7:0] r_lex_mem [DEPTH];

    sll_scanner #(
        .MAX_LEXEME (MAX_LEXEME),
        .LW         (LW),
        .CW         (CW)
    ) u_scanner (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_take       (take),
        .i_char       (i_in_char),
        .o_need_job   (need_job),
        .o_word_len   (sc_len),
        .o_word_code  (sc_code),
        .o_word_trunc (sc_trunc),
        .o_word_bank  (sc_bank),
        .o_tail       (sc_tail),
        .o_wr_en      (wr_en),
        .o_wr_addr    (wr_addr)
    );

    // Walk the job: word characters first, then the trailing words.
    assign job_total = PW'(r_job_len) + PW'(r_job_tail.cnt);
    assign in_word   = r_job_pos < PW'(r_job_len);
    assign tail_pos  = r_job_pos - PW'(r_job_len);
    assign tail_res  = tail_pos[0] ? r_job_tail.t1 : r_job_tail.t0;
    assign job_last  = (r_job_pos + PW'(1)) == job_total;

    // Each stage advances when the one after it is empty or moving.
    assign out_free  = !r_o_valid || !i_out_stall;
    assign rd_free   = !r_rd_valid || out_free;
    assign issue     = r_job_valid && rd_free;
    assign slot_free = !r_job_valid || (issue && job_last);

    // Hold a character that closes a token until the slot frees up.
    assign o_in_stall = need_job && !slot_free;
    assign take       = i_in_valid && !o_in_stall;
    assign load       = take && need_job;

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_lex_mem[wr_addr] <= i_in_char;
        end
        if (issue && in_word) begin
            r_rd_data <= r_lex_mem[{r_job_bank, r_job_pos[LW-1:0]}];
        end
    end

    // Job slot.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_job_valid <= 1'b0;
        end else if (load) begin
            r_job_valid <= 1'b1;
        end else if (issue && job_last) begin
            r_job_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_job_len   <= sc_len;
            r_job_code  <= sc_code;
            r_job_trunc <= sc_trunc;
            r_job_bank  <= sc_bank;
            r_job_tail  <= sc_tail;
            r_job_pos   <= '0;
        end else if (issue) begin
            r_job_pos <= r_job_pos + PW'(1);
        end
    end

    // Read stage.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_valid <= 1'b0;
        end else if (rd_free) begin
            r_rd_valid <= issue;
        end
    end

    always_ff @(posedge i_clk) begin
        if (issue) begin
            r_rd_mem <= in_word;
            if (in_word) begin
                r_rd_code  <= r_job_code;
                r_rd_ch    <= 8'h00;
                r_rd_last  <= (r_job_pos + PW'(1)) == PW'(r_job_len);
                r_rd_trunc <= r_job_trunc;
                r_rd_bad   <= 1'b0;
            end else begin
                r_rd_code  <= tail_res.code;
                r_rd_ch    <= tail_res.ch;
                r_rd_last  <= tail_res.last;
                r_rd_trunc <= 1'b0;
                r_rd_bad   <= tail_res.bad;
            end
        end
    end

    // Output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (out_free) begin
            r_o_valid <= r_rd_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_free && r_rd_valid) begin
            r_o_code  <= r_rd_code;
            r_o_char  <= r_rd_mem ? r_rd_data : r_rd_ch;
            r_o_last  <= r_rd_last;
            r_o_trunc <= r_rd_trunc;
            r_o_bad   <= r_rd_bad;
        end
    end

    assign o_out_valid   = r_o_valid;
    assign o_token_code  = r_o_code;
    assign o_lexeme_char = r_o_char;
    assign o_last_char   = r_o_last;
    assign o_truncated   = r_o_trunc;
    assign o_bad_char    = r_o_bad;

    // The sequencer never runs past the end of its job.
    `SLL_ASSERT_NOW(a_job_pos_in_range, r_job_valid, r_job_pos < job_total, "job position overrun")
    // Lexeme memory words are never error words.
    `SLL_ASSERT_NOW(a_mem_word_not_bad, r_rd_valid && r_rd_mem, !r_rd_bad, "bad flag on lexeme word")
    // A token burst has no holes: after a non-final word the next one is ready.
    `SLL_ASSERT_NEXT(a_burst_unbroken, r_o_valid && !i_out_stall && !r_o_last, r_o_valid, "gap in token burst")

endmodule
